// File: rtl/rbd_pkg.sv
// Package with shared types and constants for the ramp bottom detector.
package rbd_pkg;

   localparam int HEIGHT_BITS = 24;
   localparam int SPEED_BITS  = 24;
   localparam int INDEX_BITS  = 20;
   localparam int DROP_BITS   = 24;
   localparam int GAP_BITS    = 20;
   localparam int RUN_BITS    = 21;
   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 24;
   localparam int MIN_RUN_POINTS = 8;

   localparam logic [INDEX_BITS-1:0] INDEX_MAX = {INDEX_BITS{1'b1}};

   localparam logic [CSR_ADDR_BITS-1:0] CSR_MIN_DROP   = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_MIN_GAP    = 2'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_RUN_POINTS = 2'd2;

   localparam logic [GAP_BITS-1:0] MIN_GAP_RESET = GAP_BITS'(1);

   typedef struct packed {
      logic [DROP_BITS-1:0] min_drop;
      logic [GAP_BITS-1:0]  min_gap;
      logic [RUN_BITS-1:0]  run_points;
   } rbd_cfg_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0] point_index;
      logic                  is_valley;
      logic [INDEX_BITS-1:0] valley_count;
   } rbd_result_type;

endpackage

// File: rtl/ramp_bottom_detector.sv
// Top level of the ramp bottom detector: input register, tracker, result register.
//
//  channel  direction  handshake             payload
//  req      in         req_valid/req_stall   height, vertical_speed, run_start
//  rsp      out        rsp_valid/rsp_stall   point_index, is_valley, valley_count
//  csr      in         csr_valid/csr_ready   csr_index, csr_data
//
// A point goes from the input register through the tracker to the result register.
// One point is accepted every cycle unless req stalls; the single tracking update
// per cycle sets the rate. Reset is synchronous; data registers are not reset.
// A stalled rsp beat holds; req is stalled only when both registers are full.
module ramp_bottom_detector (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic signed [rbd_pkg::HEIGHT_BITS-1:0]   req_height,
   input  logic signed [rbd_pkg::SPEED_BITS-1:0]    req_vertical_speed,
   input  logic                                     req_run_start,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic [rbd_pkg::INDEX_BITS-1:0]           rsp_point_index,
   output logic                                     rsp_is_valley,
   output logic [rbd_pkg::INDEX_BITS-1:0]           rsp_valley_count,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [rbd_pkg::CSR_ADDR_BITS-1:0]        csr_index,
   input  logic [rbd_pkg::CSR_DATA_BITS-1:0]        csr_data
);
   import rbd_pkg::*;

   logic                          in_vld_ff, in_vld_in;
   logic signed [HEIGHT_BITS-1:0] in_height_ff;
   logic                          in_neg_ff;
   logic                          in_start_ff;
   logic                          out_vld_ff, out_vld_in;
   rbd_result_type                out_ff;
   rbd_result_type                result;
   rbd_cfg_type                   cfg;
   logic                          step_en;
   logic                          req_take;

   rbd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   rbd_track u_track (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step_en),
      .height    (in_height_ff),
      .speed_neg (in_neg_ff),
      .run_start (in_start_ff),
      .cfg       (cfg),
      .result    (result)
   );

   assign step_en   = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !step_en;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_vld_in  = req_take || (in_vld_ff && !step_en);
      out_vld_in = step_en || (out_vld_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_height_ff <= req_height;
         in_neg_ff    <= req_vertical_speed[SPEED_BITS-1];
         in_start_ff  <= req_run_start;
      end
      if (step_en) begin
         out_ff <= result;
      end
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_point_index  = out_ff.point_index;
   assign rsp_is_valley    = out_ff.is_valley;
   assign rsp_valley_count = out_ff.valley_count;

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_vld_ff && out_vld_ff && rsp_stall)
      else $error("input stalled while a register was free");

   a_step_fills: assert property (@(posedge clock) disable iff (reset)
      step_en |=> out_vld_ff)
      else $error("processed beat did not reach the result register");

   a_held_pending: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && !step_en |=> in_vld_ff)
      else $error("pending input beat was dropped");

endmodule

// File: rtl/rbd_csr.sv
// Configuration registers of the ramp bottom detector.
module rbd_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [rbd_pkg::CSR_ADDR_BITS-1:0]  csr_index,
   input  logic [rbd_pkg::CSR_DATA_BITS-1:0]  csr_data,
   output rbd_pkg::rbd_cfg_type               cfg
);
   import rbd_pkg::*;

   rbd_cfg_type cfg_ff;
   rbd_cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MIN_DROP:   cfg_in.min_drop   = csr_data[DROP_BITS-1:0];
            CSR_MIN_GAP:    cfg_in.min_gap    = csr_data[GAP_BITS-1:0];
            CSR_RUN_POINTS: cfg_in.run_points = csr_data[RUN_BITS-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_drop   <= '0;
         cfg_ff.min_gap    <= MIN_GAP_RESET;
         cfg_ff.run_points <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: rtl/rbd_track.sv
// Run tracking state and valley decision for one point per cycle while step_en is high.
module rbd_track (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step_en,
   input  logic signed [rbd_pkg::HEIGHT_BITS-1:0] height,
   input  logic                                speed_neg,
   input  logic                                run_start,
   input  rbd_pkg::rbd_cfg_type                cfg,
   output rbd_pkg::rbd_result_type             result
);
   import rbd_pkg::*;

   logic signed [HEIGHT_BITS-1:0] peak_ff, peak_in;
   logic signed [HEIGHT_BITS-1:0] low_ff, low_in;
   logic                          desc_ff, desc_in;
   logic [INDEX_BITS-1:0]         pc_ff, pc_in;
   logic [INDEX_BITS-1:0]         prev_ff, prev_in;
   logic                          seen_ff, seen_in;
   logic [INDEX_BITS-1:0]         count_ff, count_in;
   logic                          past_ff, past_in;

   logic signed [HEIGHT_BITS:0]   drop;
   logic [INDEX_BITS-1:0]         gap;
   logic                          deep;
   logic                          apart;
   logic                          in_run;
   logic                          valley;

   always_comb begin
      drop   = {peak_ff[HEIGHT_BITS-1], peak_ff} - {low_ff[HEIGHT_BITS-1], low_ff};
      pc_in  = (pc_ff == INDEX_MAX) ? pc_ff : pc_ff + INDEX_BITS'(1);
      past_in = past_ff || (pc_ff == INDEX_MAX);
      gap    = pc_in - prev_ff;
      deep   = !drop[HEIGHT_BITS] &&
               (drop[HEIGHT_BITS-1:0] >= HEIGHT_BITS'(cfg.min_drop));
      apart  = !seen_ff || (gap >= cfg.min_gap);
      in_run = (cfg.run_points >= RUN_BITS'(MIN_RUN_POINTS)) && !past_in &&
               ({1'b0, pc_in} < cfg.run_points);
      valley = 1'b0;
      peak_in  = peak_ff;
      low_in   = low_ff;
      desc_in  = desc_ff;
      prev_in  = prev_ff;
      seen_in  = seen_ff;
      count_in = count_ff;
      if (run_start) begin
         peak_in  = height;
         low_in   = height;
         desc_in  = 1'b0;
         pc_in    = '0;
         prev_in  = '0;
         seen_in  = 1'b0;
         count_in = '0;
         past_in  = 1'b0;
      end else if (speed_neg) begin
         desc_in = 1'b1;
         if (!desc_ff || height < low_ff) begin
            low_in = height;
         end
         if (height > peak_ff) begin
            peak_in = height;
         end
      end else if (desc_ff) begin
         if (deep && apart && in_run) begin
            valley  = 1'b1;
            seen_in = 1'b1;
            prev_in = pc_in;
            if (count_ff != INDEX_MAX) begin
               count_in = count_ff + INDEX_BITS'(1);
            end
         end
         desc_in = 1'b0;
         peak_in = height;
      end else if (height > peak_ff) begin
         peak_in = height;
      end
      result.point_index  = pc_in;
      result.is_valley    = valley;
      result.valley_count = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff  <= '0;
         low_ff   <= '0;
         desc_ff  <= 1'b0;
         pc_ff    <= '0;
         prev_ff  <= '0;
         seen_ff  <= 1'b0;
         count_ff <= '0;
         past_ff  <= 1'b0;
      end else if (step_en) begin
         peak_ff  <= peak_in;
         low_ff   <= low_in;
         desc_ff  <= desc_in;
         pc_ff    <= pc_in;
         prev_ff  <= prev_in;
         seen_ff  <= seen_in;
         count_ff <= count_in;
         past_ff  <= past_in;
      end
   end

   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      step_en && run_start |=> pc_ff == '0 && count_ff == '0 && !seen_ff && !desc_ff)
      else $error("run start did not clear the tracking state");

   a_valley_marks: assert property (@(posedge clock) disable iff (reset)
      step_en && result.is_valley |=> seen_ff && prev_ff == pc_ff && count_ff != '0)
      else $error("valley beat did not record its index");

   a_valley_inside: assert property (@(posedge clock) disable iff (reset)
      result.is_valley |-> !run_start && desc_ff &&
                           cfg.run_points >= RUN_BITS'(MIN_RUN_POINTS))
      else $error("valley flagged outside a descent or a long enough run");

endmodule

// File: test/ramp_bottom_detector_tb.sv
// Self-checking testbench for the ramp bottom detector with its own valley tracker.
module testbench;
   import rbd_pkg::*;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_SPARE = 2'd3;
   localparam logic [RUN_BITS-1:0] RUN_LIMIT = RUN_BITS'(1 << INDEX_BITS);
   localparam int HEIGHT_TOP = 8388607;
   localparam int HEIGHT_BOTTOM = -8388608;
   localparam int DIR_SPLIT = 3;
   localparam int TIMEOUT = 40000000;

   typedef struct packed {
      logic [HEIGHT_BITS-1:0] height;
      logic [SPEED_BITS-1:0]  speed;
      logic                   run_start;
      logic                   typed;
      rbd_result_type         result;
   } point_row_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic signed [HEIGHT_BITS-1:0] req_height;
   logic signed [SPEED_BITS-1:0] req_vertical_speed;
   logic req_run_start;
   logic rsp_valid;
   logic rsp_stall;
   logic [INDEX_BITS-1:0] rsp_point_index;
   logic rsp_is_valley;
   logic [INDEX_BITS-1:0] rsp_valley_count;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_ADDR_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0] csr_data;

   logic [DROP_BITS-1:0] cfg_min_drop;
   logic [GAP_BITS-1:0] cfg_min_gap;
   logic [RUN_BITS-1:0] cfg_run_points;

   logic signed [HEIGHT_BITS-1:0] trk_peak;
   logic signed [HEIGHT_BITS-1:0] trk_low;
   logic trk_descending;
   logic trk_seen;
   logic trk_past_end;
   logic [INDEX_BITS-1:0] trk_index;
   logic [INDEX_BITS-1:0] trk_last_valley;
   logic [INDEX_BITS-1:0] trk_valleys;

   rbd_result_type predicted_points [$];
   int failures = 0;
   int points_sent = 0;
   int walk_height = 0;
   bit idle_on = 1'b1;

   point_row_type descent_cases [24] = '{
      '{24'h7FFFFF, 24'h7FFFFF, 1'b0, 1'b1, '{20'd1, 1'b0, 20'd0}},
      '{24'h800000, 24'h800000, 1'b0, 1'b1, '{20'd2, 1'b0, 20'd0}},
      '{24'h000000, 24'h000000, 1'b0, 1'b1, '{20'd3, 1'b0, 20'd0}},
      '{24'h000100, 24'h000000, 1'b1, 1'b1, '{20'd0, 1'b0, 20'd0}},
      '{24'h000200, 24'hFFFFFF, 1'b0, 1'b0, '0},
      '{24'h000050, 24'hFFFFFB, 1'b0, 1'b0, '0},
      '{24'h000060, 24'h000000, 1'b0, 1'b0, '0},
      '{24'h000040, 24'hFFFFFF, 1'b0, 1'b0, '0},
      '{24'h000040, 24'h000001, 1'b0, 1'b0, '0},
      '{24'h000030, 24'hFFFFFF, 1'b0, 1'b0, '0},
      '{24'h000031, 24'h7FFFFF, 1'b0, 1'b0, '0},
      '{24'h000010, 24'hFFFFFF, 1'b0, 1'b0, '0},
      '{24'h000020, 24'h000000, 1'b0, 1'b0, '0},
      '{24'h800000, 24'h000000, 1'b1, 1'b1, '{20'd0, 1'b0, 20'd0}},
      '{24'h7FFFFF, 24'hFFFFFF, 1'b0, 1'b0, '0},
      '{24'h800000, 24'h800000, 1'b0, 1'b0, '0},
      '{24'h000000, 24'h000000, 1'b0, 1'b0, '0},
      '{24'hFFFFFC, 24'hFFFFFF, 1'b0, 1'b0, '0},
      '{24'h000000, 24'h000000, 1'b0, 1'b0, '0},
      '{24'hFFFF9C, 24'hFFFFFF, 1'b0, 1'b0, '0},
      '{24'h000010, 24'h000000, 1'b0, 1'b0, '0},
      '{24'h123456, 24'hFFFFFF, 1'b1, 1'b1, '{20'd0, 1'b0, 20'd0}},
      '{24'h000000, 24'hFFFFFF, 1'b0, 1'b0, '0},
      '{24'h000000, 24'h000000, 1'b0, 1'b0, '0}
   };

   ramp_bottom_detector i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_height         (req_height),
      .req_vertical_speed (req_vertical_speed),
      .req_run_start      (req_run_start),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_point_index    (rsp_point_index),
      .rsp_is_valley      (rsp_is_valley),
      .rsp_valley_count   (rsp_valley_count),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic rbd_result_type track_point(input logic signed [HEIGHT_BITS-1:0] height,
         input logic [SPEED_BITS-1:0] speed, input logic run_start);
      rbd_result_type res;
      logic [RUN_BITS-1:0] limit;
      logic [INDEX_BITS-1:0] spacing;
      longint drop;
      logic deep;
      logic apart;
      logic in_run;
      res = '0;
      if (run_start) begin
         trk_peak = height;
         trk_low = height;
         trk_descending = 1'b0;
         trk_index = '0;
         trk_last_valley = '0;
         trk_seen = 1'b0;
         trk_valleys = '0;
         trk_past_end = 1'b0;
         return res;
      end
      if (trk_index == INDEX_MAX) begin
         trk_past_end = 1'b1;
      end else begin
         trk_index = trk_index + 1'b1;
      end
      if (speed[SPEED_BITS-1]) begin
         if (!trk_descending) begin
            trk_descending = 1'b1;
            trk_low = height;
         end
         if (height < trk_low) trk_low = height;
         if (height > trk_peak) trk_peak = height;
      end else if (trk_descending) begin
         limit = (cfg_run_points > RUN_LIMIT) ? RUN_LIMIT : cfg_run_points;
         drop = longint'(trk_peak) - longint'(trk_low);
         deep = (drop >= 0) && (drop >= longint'(cfg_min_drop));
         spacing = trk_index - trk_last_valley;
         apart = !trk_seen || (spacing >= cfg_min_gap);
         in_run = (limit >= RUN_BITS'(MIN_RUN_POINTS)) && !trk_past_end &&
                  ({1'b0, trk_index} < limit);
         if (deep && apart && in_run) begin
            res.is_valley = 1'b1;
            trk_seen = 1'b1;
            trk_last_valley = trk_index;
            if (trk_valleys != INDEX_MAX) trk_valleys = trk_valleys + 1'b1;
         end
         trk_descending = 1'b0;
         trk_peak = height;
      end else if (height > trk_peak) begin
         trk_peak = height;
      end
      res.point_index = trk_index;
      res.valley_count = trk_valleys;
      return res;
   endfunction

   task automatic send_point(input logic [HEIGHT_BITS-1:0] height,
         input logic [SPEED_BITS-1:0] speed, input logic run_start,
         input logic typed, input rbd_result_type typed_result);
      rbd_result_type predicted;
      req_valid <= 1'b1;
      req_height <= height;
      req_vertical_speed <= speed;
      req_run_start <= run_start;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = track_point(height, speed, run_start);
      predicted_points.push_back(typed ? typed_result : predicted);
      points_sent++;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (predicted_points.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_BITS-1:0] index,
         input logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         CSR_MIN_DROP: cfg_min_drop = data[DROP_BITS-1:0];
         CSR_MIN_GAP: cfg_min_gap = data[GAP_BITS-1:0];
         CSR_RUN_POINTS: cfg_run_points = data[RUN_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic [CSR_DATA_BITS-1:0] drop,
         input logic [CSR_DATA_BITS-1:0] gap, input logic [CSR_DATA_BITS-1:0] run);
      wait_drained();
      write_reg(CSR_SPARE, CSR_DATA_BITS'($urandom));
      write_reg(CSR_MIN_DROP, drop);
      write_reg(CSR_MIN_GAP, gap);
      write_reg(CSR_RUN_POINTS, run);
      csr_valid <= 1'b0;
   endtask

   task automatic step_walk(input logic down);
      int delta;
      delta = int'($urandom_range(0, 256));
      walk_height = down ? walk_height - delta : walk_height + delta;
      if (walk_height > HEIGHT_TOP) walk_height = HEIGHT_TOP;
      if (walk_height < HEIGHT_BOTTOM) walk_height = HEIGHT_BOTTOM;
      send_point(HEIGHT_BITS'(walk_height), {down, 23'($urandom)}, 1'b0, 1'b0, '0);
   endtask

   task automatic random_points(input int count);
      int goal;
      int length;
      int steps;
      goal = points_sent + count;
      while (points_sent < goal) begin
         if ($urandom_range(0, 4) != 0) begin
            if ($urandom_range(0, 7) == 0) begin
               walk_height = int'($signed(HEIGHT_BITS'($urandom)));
            end else begin
               walk_height = int'($urandom_range(0, 8191)) - 4096;
            end
            send_point(HEIGHT_BITS'(walk_height), SPEED_BITS'($urandom), 1'b1, 1'b0, '0);
            length = $urandom_range(4, 48);
            while (length > 0 && points_sent < goal) begin
               for (steps = $urandom_range(1, 8); steps > 0 && length > 0; steps--) begin
                  step_walk(1'b1);
                  length--;
               end
               for (steps = $urandom_range(1, 5); steps > 0 && length > 0; steps--) begin
                  step_walk(1'b0);
                  length--;
               end
            end
         end else begin
            for (steps = $urandom_range(1, 8); steps > 0; steps--) begin
               send_point(HEIGHT_BITS'($urandom), SPEED_BITS'($urandom),
                          $urandom_range(0, 7) == 0, 1'b0, '0);
            end
         end
         if ($urandom_range(0, 15) == 0) wait_drained();
      end
   endtask

   initial begin
      rbd_result_type seen;
      rbd_result_type want;
      int stall_left;
      stall_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
            seen = '{rsp_point_index, rsp_is_valley, rsp_valley_count};
            if (predicted_points.size() == 0) begin
               failures++;
               $display("%0t: expected no beat, actual index %0d valley %0d count %0d",
                        $time, seen.point_index, seen.is_valley, seen.valley_count);
            end else begin
               want = predicted_points.pop_front();
               if (seen !== want) begin
                  failures++;
                  $display("%0t: expected index %0d valley %0d count %0d, %s%0d %0d %0d",
                           $time, want.point_index, want.is_valley, want.valley_count,
                           "actual ", seen.point_index, seen.is_valley,
                           seen.valley_count);
               end
            end
         end
         if (stall_left != 0) begin
            stall_left--;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 8);
         end
         rsp_stall <= (stall_left != 0);
      end
   end

   initial begin
      int row;
      int phase;
      reset = 1'b1;
      req_valid = 1'b0;
      req_height = '0;
      req_vertical_speed = '0;
      req_run_start = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      cfg_min_drop = '0;
      cfg_min_gap = MIN_GAP_RESET;
      cfg_run_points = '0;
      trk_peak = '0;
      trk_low = '0;
      trk_descending = 1'b0;
      trk_seen = 1'b0;
      trk_past_end = 1'b0;
      trk_index = '0;
      trk_last_valley = '0;
      trk_valleys = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (row = 0; row < $size(descent_cases); row++) begin
         if (row == DIR_SPLIT) configure(24'h000010, 24'd2, 24'd8);
         send_point(descent_cases[row].height, descent_cases[row].speed,
                    descent_cases[row].run_start, descent_cases[row].typed,
                    descent_cases[row].result);
      end

      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0: configure(24'hFFFFFF, 24'h0FFFFF, 24'd7);
            1: configure(24'd0, 24'd0, 24'h100000);
            2: configure(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
            default: configure(
               ($urandom_range(0, 3) == 0) ? CSR_DATA_BITS'($urandom)
                                           : CSR_DATA_BITS'($urandom_range(0, 1024)),
               ($urandom_range(0, 7) == 0) ? 24'h0FFFFF : CSR_DATA_BITS'($urandom_range(0, 12)),
               ($urandom_range(0, 3) == 0) ? 24'd8 : CSR_DATA_BITS'($urandom_range(8, 64)));
         endcase
         idle_on = (phase != 1) && (phase != 5);
         random_points(72);
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (failures == 0 && predicted_points.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// File: sim.f
rtl/rbd_pkg.sv
rtl/rbd_csr.sv
rtl/rbd_track.sv
rtl/ramp_bottom_detector.sv
test/ramp_bottom_detector_tb.sv
